@@ design/rswf_pkg.sv @@
`default_nettype none
package rswf_pkg;

  localparam int MAX_SITE = 8;
  localparam int POS_BITS = 32;
  localparam int BASE_W   = 8;
  localparam int LEN_W    = 4;
  localparam int SEL_W    = $clog2(MAX_SITE);
  localparam int HALF_W   = 16;
  localparam int WLEN_W   = 17;
  localparam int PAT_W    = MAX_SITE * BASE_W;
  localparam int CFG_W    = 64;
  localparam int CIDX_W   = 2;

  localparam logic [LEN_W-1:0]  SITE_LEN_RESET    = LEN_W'(6);
  localparam logic [HALF_W-1:0] WINDOW_HALF_RESET = HALF_W'(500);

  typedef enum logic [CIDX_W-1:0] {
    CFG_SITE_PATTERN = 2'd0,
    CFG_SITE_LENGTH  = 2'd1,
    CFG_WINDOW_HALF  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [POS_BITS-1:0] pos;
    logic [POS_BITS-1:0] seq_len;
  } hit_t;

endpackage
`default_nettype wire

@@ design/rswf_if.sv @@
`default_nettype none
interface rswf_in_if import rswf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BASE_W-1:0]   base;
  logic                first;
  logic [POS_BITS-1:0] total_len;

  modport source (output valid, base, first, total_len, input ready);
  modport sink (input valid, base, first, total_len, output ready);
endinterface

interface rswf_out_if import rswf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [POS_BITS-1:0] site_position;
  logic [POS_BITS-1:0] window_start;
  logic [POS_BITS-1:0] window_end;
  logic [WLEN_W-1:0]   window_length;

  modport source (output valid, site_position, window_start, window_end, window_length,
                  input ready);
  modport sink (input valid, site_position, window_start, window_end, window_length,
                output ready);
endinterface
`default_nettype wire

@@ design/restriction_site_window_finder.sv @@
// restriction site window finder
// in_ch carries one base per cycle while ready (base, first, total_len);
// first restarts the offset count, the history and the no-overlap mark.
// out_ch carries one beat per site hit: site position and the window of
// window_half bases around it, clipped to 0 and to total_len.
// cfg_we/cfg_index/cfg_data write site_pattern (0), site_length (1) and
// window_half (2); other indexes are ignored. write only while idle.
// throughput: one base per cycle while in_ch.ready; the site compare, the
// no-overlap check and the state update all happen in the cycle the base
// is taken. a hit reaches out_ch through two registers, one for the hit
// and one for the window arithmetic.
// reset (rst_n low, synchronous) clears history, offset and pipeline, and
// loads site_length 6, window_half 500, a zero site pattern.
// a stalled out_ch holds its beat; in_ch.ready drops only once both
// registers are full, so no beat is lost or repeated.
`default_nettype none
module restriction_site_window_finder import rswf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  rswf_in_if.sink                in_ch,
  rswf_out_if.source             out_ch,
  input  wire logic              cfg_we,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  logic [PAT_W-1:0]  pattern_r;
  logic [LEN_W-1:0]  site_length_r;
  logic [HALF_W-1:0] half_r;
  logic [LEN_W-1:0]  site_len;
  logic              hit_valid;
  logic              hit_ready;
  hit_t              hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r     <= '0;
      site_length_r <= SITE_LEN_RESET;
      half_r        <= WINDOW_HALF_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SITE_PATTERN: pattern_r     <= cfg_data[PAT_W-1:0];
        CFG_SITE_LENGTH:  site_length_r <= cfg_data[LEN_W-1:0];
        CFG_WINDOW_HALF:  half_r        <= cfg_data[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    site_len = site_length_r;
    if (site_length_r == '0) begin
      site_len = LEN_W'(1);
    end else if (site_length_r > LEN_W'(MAX_SITE)) begin
      site_len = LEN_W'(MAX_SITE);
    end
  end

  rswf_scan u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .site_pattern (pattern_r),
    .site_len     (site_len),
    .hit_valid    (hit_valid),
    .hit_ready    (hit_ready),
    .hit          (hit)
  );

  rswf_window u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .hit_valid   (hit_valid),
    .hit_ready   (hit_ready),
    .hit         (hit),
    .window_half (half_r),
    .out_ch      (out_ch)
  );

endmodule
`default_nettype wire

@@ design/rswf_scan.sv @@
`default_nettype none
module rswf_scan import rswf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  rswf_in_if.sink               in_ch,
  input  wire logic [PAT_W-1:0] site_pattern,
  input  wire logic [LEN_W-1:0] site_len,
  output logic                  hit_valid,
  input  wire logic             hit_ready,
  output hit_t                  hit
);

  logic [MAX_SITE-1:0][BASE_W-1:0] recent_r, recent_nxt;
  logic [POS_BITS-1:0]             index_r, index_nxt;
  logic [POS_BITS:0]               nas_r, nas_nxt;
  logic                            valid_r, valid_nxt;
  hit_t                            hit_r, hit_nxt;

  logic [MAX_SITE-1:0][BASE_W-1:0] pattern;
  logic [POS_BITS-1:0]             idx;
  logic [POS_BITS:0]               idx_inc;
  logic [POS_BITS:0]               pos_w;
  logic [POS_BITS:0]               nas_cur;
  logic                            match;
  logic                            found;
  logic                            accept;
  logic [LEN_W-1:0]                off;

  assign pattern     = site_pattern;
  assign in_ch.ready = !valid_r || hit_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    idx        = in_ch.first ? '0 : index_r;
    nas_cur    = in_ch.first ? '0 : nas_r;
    recent_nxt = in_ch.first ? '0 : recent_r;
    recent_nxt = {recent_nxt[MAX_SITE-2:0], in_ch.base};
    idx_inc    = {1'b0, idx} + (POS_BITS+1)'(1);
    pos_w      = idx_inc - (POS_BITS+1)'(site_len);
  end

  always_comb begin
    match = 1'b1;
    off   = '0;
    for (int k = 0; k < MAX_SITE; k++) begin
      off = site_len - LEN_W'(1) - LEN_W'(k);
      if (LEN_W'(k) < site_len && recent_nxt[off[SEL_W-1:0]] != pattern[k]) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    found = match
         && idx_inc >= (POS_BITS+1)'(site_len)
         && idx < in_ch.total_len
         && pos_w >= nas_cur;
    index_nxt       = idx_inc[POS_BITS-1:0];
    nas_nxt         = found ? idx_inc : nas_cur;
    hit_nxt.pos     = pos_w[POS_BITS-1:0];
    hit_nxt.seq_len = in_ch.total_len;
    valid_nxt       = valid_r && !hit_ready;
    if (accept) begin
      valid_nxt = found;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r <= '0;
      index_r  <= '0;
      nas_r    <= '0;
      valid_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (accept) begin
        recent_r <= recent_nxt;
        index_r  <= index_nxt;
        nas_r    <= nas_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hit_r <= hit_nxt;
    end
  end

  assign hit_valid = valid_r;
  assign hit       = hit_r;

endmodule
`default_nettype wire

@@ design/rswf_window.sv @@
`default_nettype none
module rswf_window import rswf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              hit_valid,
  output logic                   hit_ready,
  input  hit_t                   hit,
  input  wire logic [HALF_W-1:0] window_half,
  rswf_out_if.source             out_ch
);

  logic                valid_r;
  logic [POS_BITS-1:0] pos_r, ws_r, we_r;
  logic [WLEN_W-1:0]   wlen_r;

  logic [POS_BITS-1:0] ws_nxt, we_nxt;
  logic [WLEN_W-1:0]   wlen_nxt;
  logic [POS_BITS:0]   sum;
  logic                load;

  assign hit_ready = !valid_r || out_ch.ready;
  assign load      = hit_valid && hit_ready;

  always_comb begin
    ws_nxt   = (hit.pos < POS_BITS'(window_half)) ? '0 : hit.pos - POS_BITS'(window_half);
    sum      = {1'b0, hit.pos} + (POS_BITS+1)'(window_half);
    we_nxt   = (sum < {1'b0, hit.seq_len}) ? sum[POS_BITS-1:0] : hit.seq_len;
    wlen_nxt = WLEN_W'(we_nxt - ws_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (hit_ready) begin
      valid_r <= hit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pos_r  <= hit.pos;
      ws_r   <= ws_nxt;
      we_r   <= we_nxt;
      wlen_r <= wlen_nxt;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.site_position = pos_r;
  assign out_ch.window_start  = ws_r;
  assign out_ch.window_end    = we_r;
  assign out_ch.window_length = wlen_r;

endmodule
`default_nettype wire
